// ----- rtl/lockc_pkg.sv -----
// Package for the code lock controller: mode, event and message codes,
// and the reset values of the setup registers. No dependencies.
package lockc_pkg;

   typedef enum logic [2:0] {
      MODE_VERIFY = 3'd0,
      MODE_CHANGE = 3'd1,
      MODE_MENU   = 3'd2,
      MODE_LOG    = 3'd3,
      MODE_CLOCK  = 3'd4,
      MODE_MSG    = 3'd5,
      MODE_SLEEP  = 3'd6
   } mode_type;

   // request event codes
   localparam logic [2:0] OP_NONE      = 3'd0;
   localparam logic [2:0] OP_DOOR_OPEN = 3'd1;
   localparam logic [2:0] OP_DOOR_SHUT = 3'd2;
   localparam logic [2:0] OP_OVP_ON    = 3'd3;
   localparam logic [2:0] OP_OVP_OFF   = 3'd4;
   localparam logic [2:0] OP_BUTTON    = 3'd5;
   localparam logic [2:0] OP_CONFIRM   = 3'd6;
   localparam logic [2:0] OP_KNOB      = 3'd7;

   // message codes
   localparam logic [2:0] MSG_NONE    = 3'd0;
   localparam logic [2:0] MSG_NO_CODE = 3'd1;
   localparam logic [2:0] MSG_CORRECT = 3'd2;
   localparam logic [2:0] MSG_WRONG   = 3'd3;
   localparam logic [2:0] MSG_SAVED   = 3'd4;

   // setup register indexes
   localparam logic [1:0] CSR_REDRAW_PERIOD = 2'd0;
   localparam logic [1:0] CSR_MESSAGE_TIME  = 2'd1;
   localparam logic [1:0] CSR_IDLE_TIMEOUT  = 2'd2;
   localparam logic [1:0] CSR_RELOCK_TIME   = 2'd3;

   localparam logic [15:0] RST_REDRAW_PERIOD = 16'd150;
   localparam logic [15:0] RST_MESSAGE_TIME  = 16'd2000;
   localparam logic [15:0] RST_IDLE_TIMEOUT  = 16'd15000;
   localparam logic [15:0] RST_RELOCK_TIME   = 16'd10000;

   localparam logic [1:0] LED_OFF   = 2'd0;
   localparam logic [1:0] LED_ON    = 2'd1;
   localparam logic [1:0] LED_BLINK = 2'd2;

endpackage

// ----- rtl/code_lock_controller.sv -----
// Code lock controller: one request is one 1 ms tick, one response per tick.
// Latency: the response is registered and valid the cycle after the request is taken.
// Throughput: one request per cycle; a request is taken while the response register
// is empty or being drained in the same cycle.
// Reset (synchronous, active high) restores verify mode, clears entry, flags and timers,
// and loads the setup registers with their defaults. The stored code has no reset.
module code_lock_controller
   import lockc_pkg::*;
#(
   parameter int CODE_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_digit,
   input  logic        req_menu_choice,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_mode,
   output logic        rsp_alarm_on,
   output logic        rsp_lock_open,
   output logic [1:0]  rsp_status_led,
   output logic        rsp_ok_pulse,
   output logic        rsp_fail_pulse,
   output logic [2:0]  rsp_message,
   output logic [2:0]  rsp_digits_entered,
   output logic        rsp_redraw,
   output logic        rsp_attempt_valid,
   output logic [15:0] rsp_attempt_code,
   output logic        rsp_attempt_ok,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CNT_W  = $clog2(CODE_DIGITS + 1);
   localparam int PACK_N = (CODE_DIGITS < 4) ? CODE_DIGITS : 4;

   // setup registers
   logic [15:0] redraw_period_ff, message_time_ff, idle_timeout_ff, relock_time_ff;

   // tick state
   mode_type    mode_ff, mode_in;
   logic [3:0]  entry_ff [CODE_DIGITS];
   logic [3:0]  entry_in [CODE_DIGITS];
   logic [3:0]  stored_ff [CODE_DIGITS];
   logic [3:0]  stored_in [CODE_DIGITS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic        code_stored_ff, code_stored_in;
   logic        door_ff, door_in;
   logic        ovp_ff, ovp_in;
   logic        unlocked_ff, unlocked_in;
   logic        opened_ff, opened_in;
   logic [15:0] relock_ff, relock_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] msgcnt_ff, msgcnt_in;
   logic [15:0] redraw_cnt_ff, redraw_cnt_in;
   logic [2:0]  held_ff, held_in;

   // response register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_mode_ff;
   logic        rsp_alarm_ff, rsp_lock_ff, rsp_ok_ff, rsp_fail_ff;
   logic [1:0]  rsp_led_ff;
   logic [2:0]  rsp_msg_ff, rsp_digits_ff;
   logic        rsp_redraw_ff, rsp_av_ff, rsp_aok_ff;
   logic [15:0] rsp_code_ff;

   // response next values
   logic        ok_in, fail_in, strobe_in, av_in, aok_in, alarm_in;
   logic [15:0] code_in;
   logic [1:0]  led_in;

   logic        req_take;
   logic [15:0] msg_hold;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // redraw hold while a message shows, saturated
   assign msg_hold = (message_time_ff == 16'hFFFF) ? 16'hFFFF : message_time_ff + 16'd1;

   always_comb begin
      logic [2:0] ev;
      logic       skip;
      logic       full;
      logic       match;
      ev    = req_operation;
      skip  = 1'b0;
      full  = 1'b0;
      match = 1'b0;

      mode_in        = mode_ff;
      entry_in       = entry_ff;
      stored_in      = stored_ff;
      count_in       = count_ff;
      code_stored_in = code_stored_ff;
      door_in        = door_ff;
      ovp_in         = ovp_ff;
      unlocked_in    = unlocked_ff;
      opened_in      = opened_ff;
      relock_in      = relock_ff;
      idle_in        = idle_ff;
      msgcnt_in      = msgcnt_ff;
      redraw_cnt_in  = redraw_cnt_ff;
      held_in        = held_ff;
      ok_in          = 1'b0;
      fail_in        = 1'b0;
      strobe_in      = 1'b0;
      av_in          = 1'b0;
      aok_in         = 1'b0;
      code_in        = '0;

      // user activity wakes the block; the waking event is swallowed
      if (req_operation inside {OP_BUTTON, OP_CONFIRM, OP_KNOB}) begin
         idle_in = '0;
         if (mode_ff == MODE_SLEEP) begin
            mode_in       = MODE_VERIFY;
            redraw_cnt_in = '0;
            for (int i = 0; i < CODE_DIGITS; i++) entry_in[i] = '0;
            count_in      = '0;
            ev            = OP_NONE;
         end
      end

      case (req_operation)
         OP_DOOR_OPEN: begin
            door_in = 1'b1;
            if (unlocked_ff) begin
               opened_in = 1'b1;
               relock_in = '0;
            end
         end
         OP_DOOR_SHUT: begin
            door_in = 1'b0;
            if (unlocked_ff && opened_ff) begin
               unlocked_in = 1'b0;
               opened_in   = 1'b0;
               relock_in   = '0;
            end
         end
         OP_OVP_ON:  ovp_in = 1'b1;
         OP_OVP_OFF: ovp_in = 1'b0;
         default: ;
      endcase

      // relock timer
      if (relock_in != '0) begin
         relock_in = relock_in - 16'd1;
         if (relock_in == '0) begin
            unlocked_in = 1'b0;
            opened_in   = 1'b0;
         end
      end

      // idle timer; sleep waits for a message to finish
      if (mode_in != MODE_SLEEP) begin
         if (idle_in < idle_timeout_ff) begin
            idle_in = idle_in + 16'd1;
         end else if (mode_in != MODE_MSG) begin
            mode_in       = MODE_SLEEP;
            redraw_cnt_in = '0;
            skip          = 1'b1;
         end
      end

      if (!skip && ev == OP_BUTTON && mode_in != MODE_MSG) begin
         case (mode_in)
            MODE_VERIFY: mode_in = MODE_CHANGE;
            MODE_CHANGE: mode_in = MODE_MENU;
            default:     mode_in = MODE_VERIFY;
         endcase
         redraw_cnt_in = '0;
         if (mode_in == MODE_VERIFY || mode_in == MODE_CHANGE) begin
            for (int i = 0; i < CODE_DIGITS; i++) entry_in[i] = '0;
            count_in = '0;
         end
         skip = 1'b1;
      end

      if (!skip) begin
         case (mode_in)
            MODE_VERIFY, MODE_CHANGE: begin
               if (ev == OP_CONFIRM) begin
                  if (count_in < CNT_W'(CODE_DIGITS)) begin
                     for (int i = 0; i < CODE_DIGITS; i++)
                        if (count_in == CNT_W'(i)) entry_in[i] = req_digit;
                     count_in = count_in + CNT_W'(1);
                  end
                  full = (count_in >= CNT_W'(CODE_DIGITS));
                  if (full) begin
                     match = 1'b1;
                     for (int i = 0; i < CODE_DIGITS; i++)
                        if (entry_in[i] != stored_ff[i]) match = 1'b0;
                     for (int i = 0; i < PACK_N; i++)
                        code_in[15-4*i -: 4] = entry_in[i];
                     if (mode_in == MODE_CHANGE) begin
                        stored_in      = entry_in;
                        code_stored_in = 1'b1;
                        av_in          = 1'b1;
                        held_in        = MSG_SAVED;
                     end else if (!code_stored_ff) begin
                        held_in = MSG_NO_CODE;
                        code_in = '0;
                     end else begin
                        av_in  = 1'b1;
                        aok_in = match;
                        if (match) begin
                           unlocked_in = 1'b1;
                           opened_in   = 1'b0;
                           relock_in   = relock_time_ff;
                           ok_in       = 1'b1;
                           held_in     = MSG_CORRECT;
                        end else begin
                           fail_in = 1'b1;
                           held_in = MSG_WRONG;
                        end
                     end
                     msgcnt_in     = message_time_ff;
                     redraw_cnt_in = msg_hold;
                     mode_in       = MODE_MSG;
                     for (int i = 0; i < CODE_DIGITS; i++) entry_in[i] = '0;
                     count_in = '0;
                     skip     = 1'b1;
                  end
               end
            end
            MODE_MENU: begin
               if (ev == OP_CONFIRM) begin
                  mode_in       = req_menu_choice ? MODE_CLOCK : MODE_LOG;
                  redraw_cnt_in = '0;
                  skip          = 1'b1;
               end
            end
            MODE_LOG, MODE_CLOCK: begin
               if (ev == OP_CONFIRM) begin
                  mode_in       = MODE_MENU;
                  redraw_cnt_in = '0;
                  skip          = 1'b1;
               end
            end
            MODE_MSG: begin
               if (msgcnt_in != '0) begin
                  msgcnt_in = msgcnt_in - 16'd1;
               end else begin
                  mode_in       = MODE_VERIFY;
                  redraw_cnt_in = '0;
                  for (int i = 0; i < CODE_DIGITS; i++) entry_in[i] = '0;
                  count_in = '0;
                  skip     = 1'b1;
               end
            end
            MODE_SLEEP: ;
            default: begin
               mode_in       = MODE_VERIFY;
               redraw_cnt_in = '0;
               for (int i = 0; i < CODE_DIGITS; i++) entry_in[i] = '0;
               count_in = '0;
               skip     = 1'b1;
            end
         endcase
      end

      // redraw timer
      if (!skip) begin
         if (redraw_cnt_in != '0) begin
            redraw_cnt_in = redraw_cnt_in - 16'd1;
         end else begin
            redraw_cnt_in = redraw_period_ff;
            strobe_in     = 1'b1;
         end
      end

      if (mode_in != MODE_MSG) held_in = MSG_NONE;
   end

   assign alarm_in = !unlocked_in && (door_in || ovp_in);
   assign led_in   = alarm_in ? LED_BLINK : (unlocked_in ? LED_ON : LED_OFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         redraw_period_ff <= RST_REDRAW_PERIOD;
         message_time_ff  <= RST_MESSAGE_TIME;
         idle_timeout_ff  <= RST_IDLE_TIMEOUT;
         relock_time_ff   <= RST_RELOCK_TIME;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REDRAW_PERIOD: redraw_period_ff <= csr_wdata;
            CSR_MESSAGE_TIME:  message_time_ff  <= csr_wdata;
            CSR_IDLE_TIMEOUT:  idle_timeout_ff  <= csr_wdata;
            CSR_RELOCK_TIME:   relock_time_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_VERIFY;
         for (int i = 0; i < CODE_DIGITS; i++) entry_ff[i] <= '0;
         count_ff       <= '0;
         code_stored_ff <= 1'b0;
         door_ff        <= 1'b0;
         ovp_ff         <= 1'b0;
         unlocked_ff    <= 1'b0;
         opened_ff      <= 1'b0;
         relock_ff      <= '0;
         idle_ff        <= '0;
         msgcnt_ff      <= '0;
         redraw_cnt_ff  <= '0;
         held_ff        <= MSG_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            mode_ff        <= mode_in;
            entry_ff       <= entry_in;
            count_ff       <= count_in;
            code_stored_ff <= code_stored_in;
            door_ff        <= door_in;
            ovp_ff         <= ovp_in;
            unlocked_ff    <= unlocked_in;
            opened_ff      <= opened_in;
            relock_ff      <= relock_in;
            idle_ff        <= idle_in;
            msgcnt_ff      <= msgcnt_in;
            redraw_cnt_ff  <= redraw_cnt_in;
            held_ff        <= held_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stored code and response payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         stored_ff     <= stored_in;
         rsp_mode_ff   <= mode_in;
         rsp_alarm_ff  <= alarm_in;
         rsp_lock_ff   <= unlocked_in;
         rsp_led_ff    <= led_in;
         rsp_ok_ff     <= ok_in;
         rsp_fail_ff   <= fail_in;
         rsp_msg_ff    <= held_in;
         rsp_digits_ff <= 3'(count_in);
         rsp_redraw_ff <= strobe_in;
         rsp_av_ff     <= av_in;
         rsp_code_ff   <= code_in;
         rsp_aok_ff    <= aok_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = rsp_mode_ff;
   assign rsp_alarm_on       = rsp_alarm_ff;
   assign rsp_lock_open      = rsp_lock_ff;
   assign rsp_status_led     = rsp_led_ff;
   assign rsp_ok_pulse       = rsp_ok_ff;
   assign rsp_fail_pulse     = rsp_fail_ff;
   assign rsp_message        = rsp_msg_ff;
   assign rsp_digits_entered = rsp_digits_ff;
   assign rsp_redraw         = rsp_redraw_ff;
   assign rsp_attempt_valid  = rsp_av_ff;
   assign rsp_attempt_code   = rsp_code_ff;
   assign rsp_attempt_ok     = rsp_aok_ff;

`ifndef SYNTH
   // a correct code disarms and shows a message in the same tick
   a_ok_unlocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok_pulse |-> rsp_lock_open && rsp_mode == MODE_MSG && rsp_attempt_ok)
      else $error("ok pulse without unlock and message");

   // a match flag only comes with an attempt record
   a_aok_has_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_attempt_ok |-> rsp_attempt_valid && !rsp_fail_pulse)
      else $error("attempt_ok without attempt record");

   // message code is only shown in message mode
   a_msg_only_in_msg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != MODE_MSG |-> rsp_message == MSG_NONE)
      else $error("message code outside message mode");

   // alarm never sounds while disarmed
   a_no_alarm_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lock_open |-> !rsp_alarm_on && rsp_status_led == LED_ON)
      else $error("alarm while disarmed");
`endif

endmodule

// ----- sim/tb_code_lock_controller.sv -----
`timescale 1ns / 1ps
// Testbench for code_lock_controller: directed and random tick requests checked
// against a cycle-free model of the lock. Depends on rtl/lockc_pkg.sv.
module tb_code_lock_controller;
   import lockc_pkg::*;

   localparam int NDIG        = 4;
   localparam int HALF_PERIOD = 10;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [2:0]  mode;
      logic        alarm_on;
      logic        lock_open;
      logic [1:0]  status_led;
      logic        ok_pulse;
      logic        fail_pulse;
      logic [2:0]  message;
      logic [2:0]  digits_entered;
      logic        redraw;
      logic        attempt_valid;
      logic [15:0] attempt_code;
      logic        attempt_ok;
   } tick_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = OP_NONE;
   logic [3:0]  req_digit = 4'd0;
   logic        req_menu_choice = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_mode;
   logic        rsp_alarm_on;
   logic        rsp_lock_open;
   logic [1:0]  rsp_status_led;
   logic        rsp_ok_pulse;
   logic        rsp_fail_pulse;
   logic [2:0]  rsp_message;
   logic [2:0]  rsp_digits_entered;
   logic        rsp_redraw;
   logic        rsp_attempt_valid;
   logic [15:0] rsp_attempt_code;
   logic        rsp_attempt_ok;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_REDRAW_PERIOD;
   logic [15:0] csr_wdata = 16'd0;

   code_lock_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_digit          (req_digit),
      .req_menu_choice    (req_menu_choice),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mode           (rsp_mode),
      .rsp_alarm_on       (rsp_alarm_on),
      .rsp_lock_open      (rsp_lock_open),
      .rsp_status_led     (rsp_status_led),
      .rsp_ok_pulse       (rsp_ok_pulse),
      .rsp_fail_pulse     (rsp_fail_pulse),
      .rsp_message        (rsp_message),
      .rsp_digits_entered (rsp_digits_entered),
      .rsp_redraw         (rsp_redraw),
      .rsp_attempt_valid  (rsp_attempt_valid),
      .rsp_attempt_code   (rsp_attempt_code),
      .rsp_attempt_ok     (rsp_attempt_ok),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // lock model state
   mode_type                lk_mode;
   logic [0:NDIG-1][3:0]    lk_entry;
   logic [2:0]              lk_count;
   logic [0:NDIG-1][3:0]    lk_code;
   logic                    lk_have_code, lk_door, lk_ovp, lk_unlocked, lk_opened;
   logic [15:0]             lk_relock_cnt, lk_idle_cnt, lk_msg_cnt, lk_redraw_cnt;
   logic [2:0]              lk_held_msg;
   logic [15:0]             cfg_redraw, cfg_msg_time, cfg_idle, cfg_relock;
   tick_status_type         lk_out;

   tick_status_type         due_status[$];
   tick_status_type         want;
   int                      tx_idle_pct = 0;
   int                      rx_idle_pct = 0;
   int                      n_sent = 0;
   int                      n_rsp = 0;
   int                      n_errors = 0;
   int                      n_saved = 0;
   int                      n_unlock = 0;
   int                      n_wrong = 0;
   int                      n_sleep = 0;
   int                      cycle_count = 0;

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rx_idle_pct);

   function automatic void reset_lock_model();
      lk_mode       = MODE_VERIFY;
      lk_entry      = '0;
      lk_count      = 3'd0;
      lk_code       = '0;
      lk_have_code  = 1'b0;
      lk_door       = 1'b0;
      lk_ovp        = 1'b0;
      lk_unlocked   = 1'b0;
      lk_opened     = 1'b0;
      lk_relock_cnt = 16'd0;
      lk_idle_cnt   = 16'd0;
      lk_msg_cnt    = 16'd0;
      lk_redraw_cnt = 16'd0;
      lk_held_msg   = MSG_NONE;
      cfg_redraw    = RST_REDRAW_PERIOD;
      cfg_msg_time  = RST_MESSAGE_TIME;
      cfg_idle      = RST_IDLE_TIMEOUT;
      cfg_relock    = RST_RELOCK_TIME;
   endfunction

   function automatic void enter_mode(mode_type m);
      lk_mode       = m;
      lk_redraw_cnt = 16'd0;
      if (m == MODE_SLEEP) n_sleep++;
      if (m == MODE_VERIFY || m == MODE_CHANGE) begin
         lk_entry = '0;
         lk_count = 3'd0;
      end
   endfunction

   function automatic void hold_message(logic [2:0] code);
      logic [16:0] hold;
      hold          = {1'b0, cfg_msg_time} + 17'd1;
      lk_msg_cnt    = cfg_msg_time;
      lk_redraw_cnt = hold[16] ? 16'hFFFF : hold[15:0];
      lk_mode       = MODE_MSG;
      lk_held_msg   = code;
   endfunction

   // Timers, mode button, mode FSM and redraw timer; returns the redraw strobe.
   function automatic logic advance_lock(logic [2:0] ev, logic [3:0] dig, logic choice);
      logic match;
      if (lk_relock_cnt != 16'd0) begin
         lk_relock_cnt--;
         if (lk_relock_cnt == 16'd0) begin
            lk_unlocked = 1'b0;
            lk_opened   = 1'b0;
         end
      end
      if (lk_mode != MODE_SLEEP) begin
         if (lk_idle_cnt < cfg_idle) begin
            lk_idle_cnt++;
         end else if (lk_mode != MODE_MSG) begin
            enter_mode(MODE_SLEEP);
            return 1'b0;
         end
      end
      if (ev == OP_BUTTON && lk_mode != MODE_MSG) begin
         case (lk_mode)
            MODE_VERIFY: enter_mode(MODE_CHANGE);
            MODE_CHANGE: enter_mode(MODE_MENU);
            default:     enter_mode(MODE_VERIFY);
         endcase
         return 1'b0;
      end
      case (lk_mode)
         MODE_VERIFY, MODE_CHANGE: begin
            if (ev == OP_CONFIRM && lk_count < NDIG) begin
               lk_entry[lk_count] = dig;
               lk_count++;
            end
            if (ev == OP_CONFIRM && lk_count >= NDIG) begin
               if (lk_mode == MODE_CHANGE) begin
                  lk_code              = lk_entry;
                  lk_have_code         = 1'b1;
                  lk_out.attempt_valid = 1'b1;
                  lk_out.attempt_code  = lk_entry;
                  n_saved++;
                  hold_message(MSG_SAVED);
               end else if (!lk_have_code) begin
                  hold_message(MSG_NO_CODE);
               end else begin
                  match = (lk_entry == lk_code);
                  if (match) begin
                     lk_unlocked     = 1'b1;
                     lk_opened       = 1'b0;
                     lk_relock_cnt   = cfg_relock;
                     lk_out.ok_pulse = 1'b1;
                     n_unlock++;
                     hold_message(MSG_CORRECT);
                  end else begin
                     lk_out.fail_pulse = 1'b1;
                     n_wrong++;
                     hold_message(MSG_WRONG);
                  end
                  lk_out.attempt_valid = 1'b1;
                  lk_out.attempt_code  = lk_entry;
                  lk_out.attempt_ok    = match;
               end
               lk_entry = '0;
               lk_count = 3'd0;
               return 1'b0;
            end
         end
         MODE_MENU: begin
            if (ev == OP_CONFIRM) begin
               enter_mode(choice ? MODE_CLOCK : MODE_LOG);
               return 1'b0;
            end
         end
         MODE_LOG, MODE_CLOCK: begin
            if (ev == OP_CONFIRM) begin
               enter_mode(MODE_MENU);
               return 1'b0;
            end
         end
         MODE_MSG: begin
            if (lk_msg_cnt != 16'd0) begin
               lk_msg_cnt--;
            end else begin
               enter_mode(MODE_VERIFY);
               return 1'b0;
            end
         end
         MODE_SLEEP: ;
         default: begin
            enter_mode(MODE_VERIFY);
            return 1'b0;
         end
      endcase
      if (lk_redraw_cnt != 16'd0) begin
         lk_redraw_cnt--;
         return 1'b0;
      end
      lk_redraw_cnt = cfg_redraw;
      return 1'b1;
   endfunction

   // One tick of the lock: updates the model and queues the status it must report.
   function automatic void step_lock(logic [2:0] op, logic [3:0] dig, logic choice);
      logic [2:0] ev;
      logic       alarm;
      ev     = op;
      lk_out = '0;
      if (op == OP_BUTTON || op == OP_CONFIRM || op == OP_KNOB) begin
         lk_idle_cnt = 16'd0;
         if (lk_mode == MODE_SLEEP) begin
            enter_mode(MODE_VERIFY);
            ev = OP_NONE;   // waking event is consumed
         end
      end
      case (op)
         OP_DOOR_OPEN: begin
            lk_door = 1'b1;
            if (lk_unlocked) begin
               lk_opened     = 1'b1;
               lk_relock_cnt = 16'd0;
            end
         end
         OP_DOOR_SHUT: begin
            lk_door = 1'b0;
            if (lk_unlocked && lk_opened) begin
               lk_unlocked   = 1'b0;
               lk_opened     = 1'b0;
               lk_relock_cnt = 16'd0;
            end
         end
         OP_OVP_ON:  lk_ovp = 1'b1;
         OP_OVP_OFF: lk_ovp = 1'b0;
         default: ;
      endcase
      lk_out.redraw = advance_lock(ev, dig, choice);
      if (lk_mode != MODE_MSG) lk_held_msg = MSG_NONE;
      alarm = !lk_unlocked && (lk_door || lk_ovp);
      lk_out.mode           = lk_mode;
      lk_out.alarm_on       = alarm;
      lk_out.lock_open      = lk_unlocked;
      lk_out.status_led     = alarm ? LED_BLINK : (lk_unlocked ? LED_ON : LED_OFF);
      lk_out.message        = lk_held_msg;
      lk_out.digits_entered = lk_count;
      due_status.push_back(lk_out);
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR response %0d: %s", n_rsp, what);
      n_errors++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (due_status.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = due_status.pop_front();
            check_field("mode", 16'(rsp_mode), 16'(want.mode));
            check_field("alarm_on", 16'(rsp_alarm_on), 16'(want.alarm_on));
            check_field("lock_open", 16'(rsp_lock_open), 16'(want.lock_open));
            check_field("status_led", 16'(rsp_status_led), 16'(want.status_led));
            check_field("ok_pulse", 16'(rsp_ok_pulse), 16'(want.ok_pulse));
            check_field("fail_pulse", 16'(rsp_fail_pulse), 16'(want.fail_pulse));
            check_field("message", 16'(rsp_message), 16'(want.message));
            check_field("digits_entered", 16'(rsp_digits_entered),
                        16'(want.digits_entered));
            check_field("redraw", 16'(rsp_redraw), 16'(want.redraw));
            check_field("attempt_valid", 16'(rsp_attempt_valid), 16'(want.attempt_valid));
            check_field("attempt_code", rsp_attempt_code, want.attempt_code);
            check_field("attempt_ok", 16'(rsp_attempt_ok), 16'(want.attempt_ok));
         end
      end
   end

   // Valid is only dropped for a gap, so back-to-back requests keep it high.
   task automatic send_tick(input logic [2:0] op, input logic [3:0] dig, input logic choice);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_digit       <= dig;
      req_menu_choice <= choice;
      do @(posedge clock); while (!req_ready);
      step_lock(op, dig, choice);
      n_sent++;
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_status.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [15:0] redraw_p, input logic [15:0] msg_t,
                             input logic [15:0] idle_t, input logic [15:0] relock_t);
      wait_all_results();
      write_reg(CSR_REDRAW_PERIOD, redraw_p);
      write_reg(CSR_MESSAGE_TIME, msg_t);
      write_reg(CSR_IDLE_TIMEOUT, idle_t);
      write_reg(CSR_RELOCK_TIME, relock_t);
      csr_we <= 1'b0;
      cfg_redraw   = redraw_p;
      cfg_msg_time = msg_t;
      cfg_idle     = idle_t;
      cfg_relock   = relock_t;
   endtask

   // Walk to verify or change mode, then key in four digits.
   task automatic enter_code(input logic to_change, input logic use_stored,
                             input logic mangle);
      logic [0:NDIG-1][3:0] code;
      mode_type             target;
      int                   tries;
      int                   idx;
      target = to_change ? MODE_CHANGE : MODE_VERIFY;
      tries  = 0;
      while (lk_mode != target && tries < 24) begin
         tries++;
         if (lk_mode == MODE_MSG)
            send_tick(OP_NONE, 4'($urandom_range(15)), 1'($urandom_range(1)));
         else if (lk_mode == MODE_SLEEP)
            send_tick(OP_KNOB, 4'($urandom_range(15)), 1'($urandom_range(1)));
         else
            send_tick(OP_BUTTON, 4'($urandom_range(15)), 1'($urandom_range(1)));
      end
      for (int i = 0; i < NDIG; i++) code[i] = 4'($urandom_range(15));
      if (use_stored && lk_have_code) begin
         code = lk_code;
         if (mangle) begin
            idx       = $urandom_range(NDIG - 1);
            code[idx] = code[idx] + 4'd1;
         end
      end
      for (int i = 0; i < NDIG; i++) send_tick(OP_CONFIRM, code[i], 1'($urandom_range(1)));
   endtask

   task automatic test_code_entry();
      // verify before any code is stored
      send_tick(OP_CONFIRM, 4'd0, 1'b0);
      send_tick(OP_CONFIRM, 4'd15, 1'b1);
      send_tick(OP_CONFIRM, 4'd9, 1'b0);
      send_tick(OP_CONFIRM, 4'd0, 1'b1);
      send_tick(OP_BUTTON, 4'd3, 1'b0);   // ignored while the message shows
      send_tick(OP_BUTTON, 4'd3, 1'b0);
      send_tick(OP_CONFIRM, 4'd1, 1'b0);
      send_tick(OP_CONFIRM, 4'd2, 1'b0);
      send_tick(OP_CONFIRM, 4'd3, 1'b0);
      send_tick(OP_CONFIRM, 4'd15, 1'b0);
      send_tick(OP_KNOB, 4'd8, 1'b1);
      send_tick(OP_CONFIRM, 4'd1, 1'b0);
      send_tick(OP_CONFIRM, 4'd2, 1'b0);
      send_tick(OP_CONFIRM, 4'd3, 1'b0);
      send_tick(OP_CONFIRM, 4'd14, 1'b0);
      send_tick(OP_OVP_ON, 4'd0, 1'b0);
      send_tick(OP_CONFIRM, 4'd1, 1'b1);
      send_tick(OP_CONFIRM, 4'd2, 1'b1);
      send_tick(OP_CONFIRM, 4'd3, 1'b1);
      send_tick(OP_CONFIRM, 4'd15, 1'b1);
   endtask

   task automatic test_doors_and_menu();
      send_tick(OP_DOOR_SHUT, 4'd5, 1'b0);   // close without open keeps it disarmed
      send_tick(OP_DOOR_OPEN, 4'd5, 1'b0);
      send_tick(OP_DOOR_SHUT, 4'd5, 1'b0);
      send_tick(OP_OVP_OFF, 4'd5, 1'b0);
      send_tick(OP_BUTTON, 4'd5, 1'b0);
      send_tick(OP_BUTTON, 4'd5, 1'b0);
      send_tick(OP_CONFIRM, 4'd5, 1'b1);
      send_tick(OP_CONFIRM, 4'd5, 1'b0);
      send_tick(OP_CONFIRM, 4'd5, 1'b0);
      send_tick(OP_BUTTON, 4'd5, 1'b1);
   endtask

   task automatic test_random_traffic(input int n_req);
      int start;
      int pick;
      int run;
      start = n_sent;
      while (n_sent - start < n_req) begin
         pick = $urandom_range(99);
         if (pick < 28)
            enter_code(1'b0, 1'b1, ($urandom_range(3) == 0));
         else if (pick < 34)
            enter_code(1'b0, 1'b0, 1'b0);
         else if (pick < 40)
            enter_code(1'b1, 1'b0, 1'b0);
         else if (pick < 50)
            send_tick(OP_BUTTON, 4'($urandom_range(15)), 1'($urandom_range(1)));
         else if (pick < 60)
            send_tick(OP_CONFIRM, 4'($urandom_range(15)), 1'($urandom_range(1)));
         else if (pick < 70)
            send_tick($urandom_range(1) ? OP_DOOR_OPEN : OP_DOOR_SHUT,
                      4'($urandom_range(15)), 1'($urandom_range(1)));
         else if (pick < 76)
            send_tick($urandom_range(1) ? OP_OVP_ON : OP_OVP_OFF,
                      4'($urandom_range(15)), 1'($urandom_range(1)));
         else if (pick < 83)
            send_tick(OP_KNOB, 4'($urandom_range(15)), 1'($urandom_range(1)));
         else begin
            run = $urandom_range(1, 12);
            repeat (run) send_tick(OP_NONE, 4'($urandom_range(15)), 1'($urandom_range(1)));
         end
         if ($urandom_range(39) == 0) wait_all_results();
      end
   endtask

   // All timers at their maximum: the redraw hold of the message saturates,
   // so no redraw strobe shows in the first ticks the message is held.
   task automatic test_long_hold();
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      enter_code(1'b0, 1'b1, 1'b0);
      repeat (16) send_tick(OP_NONE, 4'($urandom_range(15)), 1'($urandom_range(1)));
      send_tick(OP_KNOB, 4'($urandom_range(15)), 1'($urandom_range(1)));
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d requests sent", cycle_count, n_sent);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      reset_lock_model();

      tx_idle_pct = 6;
      rx_idle_pct = 83;
      set_timing(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      test_code_entry();
      test_doors_and_menu();
      set_timing(16'd5, 16'd4, 16'd40, 16'd25);
      test_random_traffic(180);

      tx_idle_pct = 83;
      rx_idle_pct = 6;
      set_timing(16'd0, 16'd0, 16'd0, 16'd0);
      test_random_traffic(40);
      set_timing(16'd2, 16'd1, 16'd12, 16'd1);
      test_random_traffic(150);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_timing(16'd11, 16'd9, 16'd100, 16'd0);
      test_random_traffic(180);
      test_long_hold();

      wait_all_results();
      repeat (4) @(posedge clock);
      $display("Sent %0d tick requests over six timer settings, %0d responses checked.",
               n_sent, n_rsp);
      $display("Lock saw %0d code saves, %0d unlocks, %0d wrong codes, %0d sleeps.",
               n_saved, n_unlock, n_wrong, n_sleep);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lockc_pkg.sv
rtl/code_lock_controller.sv
sim/tb_code_lock_controller.sv
